// ----- rtl/core/pfe_pkg.sv -----
// Shared types and constants for the Playfair encoder.
// No dependencies; pfe_queue, pfe_front, pfe_back and the top level import this package.
package pfe_pkg;

	// Square geometry and alphabet
	localparam int SIDE        = 5;
	localparam int CELLS       = SIDE * SIDE;
	localparam int LETTERS     = 26;
	localparam int LETTER_W    = 5;
	localparam int ROWCOL_W    = 3;
	localparam int POS_W       = 2 * ROWCOL_W;
	localparam int CELL_IDX_W  = $clog2(CELLS);
	localparam int LETTER_IDX_W = $clog2(LETTERS);
	localparam int FILL_W      = $clog2(CELLS + 1);

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Configuration registers
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = LETTER_W;
	localparam logic [CFG_INDEX_W-1:0] CFG_OMITTED = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FILLER  = 1'b1;
	localparam logic [LETTER_W-1:0] OMITTED_RESET = 5'd16;
	localparam logic [LETTER_W-1:0] FILLER_RESET  = 5'd23;

	// Input actions
	typedef enum logic [1:0] {
		ACT_KEY_LETTER  = 2'd0,
		ACT_KEY_END     = 2'd1,
		ACT_TEXT_LETTER = 2'd2,
		ACT_TEXT_END    = 2'd3
	} action_t;

	// Commands handed from front to back
	typedef enum logic [1:0] {
		OP_KEY     = 2'd0,
		OP_KEY_END = 2'd1,
		OP_PAIR    = 2'd2,
		OP_BAD     = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0]          action;
		logic [LETTER_W-1:0] letter;
	} item_t;

	typedef struct packed {
		logic [LETTER_W-1:0] cipher_letter;
		logic                bad_letter;
		logic                last;
	} result_t;

	// For key commands a is the letter and b the omitted letter at issue time;
	// for pairs a and b are the two plaintext letters.
	typedef struct packed {
		op_t                 op;
		logic [LETTER_W-1:0] a;
		logic [LETTER_W-1:0] b;
	} cmd_t;

endpackage

// ----- rtl/core/pfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/pfe_queue.sv -----
// Small command FIFO between the front classifier and the back executor.
// Depends on pfe_pkg for the command type and depth.
module pfe_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  pfe_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          cmd_valid,
	output pfe_pkg::cmd_t cmd
);
	import pfe_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = slot_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && cmd_valid;

	// Payload slots
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && full && !pop) |=> $stable(wr_ptr_q))
		else $error("queue write pointer moved while full");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");
`endif

endmodule

// ----- rtl/core/pfe_front.sv -----
// Front end: accepts items, pairs text letters and issues commands.
// Depends on pfe_pkg for item and command types.
module pfe_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  pfe_pkg::item_t               item,
	input  logic [pfe_pkg::LETTER_W-1:0] omitted,
	input  logic [pfe_pkg::LETTER_W-1:0] filler,
	input  logic                         q_full,
	output logic                         push,
	output pfe_pkg::cmd_t                push_cmd
);
	import pfe_pkg::*;

	logic [LETTER_W-1:0] pend_letter_q;
	logic                pend_valid_q;
	logic                take;
	logic                bad;
	logic                pend_load;
	logic                pend_clear;

	assign item_stall = q_full;
	assign take       = item_valid && !q_full;
	assign bad        = (item.letter >= LETTER_W'(LETTERS)) || (item.letter == omitted);

	// Classify the item into a command, if any
	always_comb begin
		push       = 1'b0;
		push_cmd   = '{op: OP_KEY, a: item.letter, b: omitted};
		pend_load  = 1'b0;
		pend_clear = 1'b0;
		unique case (action_t'(item.action))
			ACT_KEY_LETTER: begin
				push = take;
			end
			ACT_KEY_END: begin
				push     = take;
				push_cmd = '{op: OP_KEY_END, a: item.letter, b: omitted};
			end
			ACT_TEXT_LETTER: begin
				if (bad) begin
					push     = take;
					push_cmd = '{op: OP_BAD, a: item.letter, b: omitted};
				end else if (!pend_valid_q) begin
					pend_load = take;
				end else if (pend_letter_q == item.letter) begin
					// doubled letter: split with filler, letter stays pending
					push     = take;
					push_cmd = '{op: OP_PAIR, a: pend_letter_q, b: filler};
				end else begin
					push       = take;
					push_cmd   = '{op: OP_PAIR, a: pend_letter_q, b: item.letter};
					pend_clear = take;
				end
			end
			ACT_TEXT_END: begin
				if (pend_valid_q) begin
					push       = take;
					push_cmd   = '{op: OP_PAIR, a: pend_letter_q, b: filler};
					pend_clear = take;
				end
			end
			default: ;
		endcase
	end

	// Pending letter of an open pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_letter_q <= '0;
			pend_valid_q  <= 1'b0;
		end else if (pend_load) begin
			pend_letter_q <= item.letter;
			pend_valid_q  <= 1'b1;
		end else if (pend_clear) begin
			pend_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/pfe_back.sv -----
// Back end: builds the square, encrypts pairs through two small RAMs and reports dropped letters.
// Depends on pfe_pkg and pfe_ram.
module pfe_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  pfe_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	output logic             result_valid,
	input  logic             result_stall,
	output pfe_pkg::result_t result
);
	import pfe_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEY_END,
		ST_RD_B,
		ST_CALC,
		ST_SQ2,
		ST_E2,
		ST_OUT1,
		ST_OUT2,
		ST_BAD
	} state_t;

	state_t                state_q;
	logic [LETTERS-1:0]    used_q;
	logic [FILL_W-1:0]     fill_q;
	logic [ROWCOL_W-1:0]   fill_row_q;
	logic [ROWCOL_W-1:0]   fill_col_q;
	logic [LETTER_W-1:0]   walk_q;
	logic [LETTER_W-1:0]   omit_q;
	logic [LETTER_W-1:0]   b_q;
	logic [ROWCOL_W-1:0]   r1_q;
	logic [ROWCOL_W-1:0]   c1_q;
	logic [CELL_IDX_W-1:0] idx2_q;
	logic [LETTER_W-1:0]   e1_q;
	logic [LETTER_W-1:0]   e2_q;
	logic                  res_valid_q;
	result_t               res_q;

	logic [LETTER_W-1:0]     place_v;
	logic [LETTER_W-1:0]     place_omit;
	logic                    used_bit;
	logic                    placeable;
	logic                    place_en;
	logic                    load_ok;
	logic                    res_load;
	logic                    b_bad;
	logic [LETTER_IDX_W-1:0] pos_raddr;
	logic [POS_W-1:0]        pos_rdata;
	logic [CELL_IDX_W-1:0]   sq_raddr;
	logic [LETTER_W-1:0]     sq_rdata;
	logic [ROWCOL_W-1:0]     r2;
	logic [ROWCOL_W-1:0]     c2;
	logic [CELL_IDX_W-1:0]   idx1;
	logic [CELL_IDX_W-1:0]   idx2;

	function automatic logic [ROWCOL_W-1:0] wrap_inc(input logic [ROWCOL_W-1:0] x);
		return (x == ROWCOL_W'(SIDE - 1)) ? '0 : x + ROWCOL_W'(1);
	endfunction

	function automatic logic [CELL_IDX_W-1:0] cell_idx(input logic [ROWCOL_W-1:0] r,
			input logic [ROWCOL_W-1:0] c);
		return CELL_IDX_W'(r) * CELL_IDX_W'(SIDE) + CELL_IDX_W'(c);
	endfunction

	// Placement of one letter, from a key command or the key-end walk
	always_comb begin
		place_v    = (state_q == ST_KEY_END) ? walk_q : cmd.a;
		place_omit = (state_q == ST_KEY_END) ? omit_q : cmd.b;
		used_bit   = (place_v < LETTER_W'(LETTERS)) ? used_q[place_v] : 1'b1;
		placeable  = !used_bit && (place_v != place_omit) && (fill_q < FILL_W'(CELLS));
		place_en   = placeable && ((state_q == ST_KEY_END) ||
			(state_q == ST_IDLE && cmd_valid && cmd.op == OP_KEY));
	end

	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	assign load_ok  = !res_valid_q || !result_stall;
	assign res_load = load_ok &&
		(state_q == ST_OUT1 || state_q == ST_OUT2 || state_q == ST_BAD);
	assign b_bad    = (b_q >= LETTER_W'(LETTERS));

	// Position lookup and rule selection
	always_comb begin
		pos_raddr = (state_q == ST_IDLE) ? cmd.a : (b_bad ? '0 : b_q);
		r2 = b_bad ? '0 : pos_rdata[POS_W-1:ROWCOL_W];
		c2 = b_bad ? '0 : pos_rdata[ROWCOL_W-1:0];
		if (r1_q == r2) begin
			idx1 = cell_idx(r1_q, wrap_inc(c1_q));
			idx2 = cell_idx(r2, wrap_inc(c2));
		end else if (c1_q == c2) begin
			idx1 = cell_idx(wrap_inc(r1_q), c1_q);
			idx2 = cell_idx(wrap_inc(r2), c2);
		end else begin
			idx1 = cell_idx(r1_q, c2);
			idx2 = cell_idx(r2, c1_q);
		end
		sq_raddr = (state_q == ST_CALC) ? idx1 : idx2_q;
	end

	// letter -> {row, col}
	pfe_ram #(.WIDTH(POS_W), .DEPTH(LETTERS)) u_pos_ram (
		.clk   (clk),
		.we    (place_en),
		.waddr (place_v[LETTER_IDX_W-1:0]),
		.wdata ({fill_row_q, fill_col_q}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	// cell -> letter
	pfe_ram #(.WIDTH(LETTER_W), .DEPTH(CELLS)) u_sq_ram (
		.clk   (clk),
		.we    (place_en),
		.waddr (fill_q[CELL_IDX_W-1:0]),
		.wdata (place_v),
		.raddr (sq_raddr),
		.rdata (sq_rdata)
	);

	// Payload registers of the pair datapath
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			b_q    <= cmd.b;
			omit_q <= cmd.b;
		end
		if (state_q == ST_RD_B) begin
			r1_q <= pos_rdata[POS_W-1:ROWCOL_W];
			c1_q <= pos_rdata[ROWCOL_W-1:0];
		end
		if (state_q == ST_CALC) begin
			idx2_q <= idx2;
		end
		if (state_q == ST_SQ2) begin
			e1_q <= sq_rdata;
		end
		if (state_q == ST_E2) begin
			e2_q <= sq_rdata;
		end
	end

	// Sequencer, square fill state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			fill_q      <= '0;
			fill_row_q  <= '0;
			fill_col_q  <= '0;
			walk_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			if (place_en) begin
				used_q[place_v[LETTER_IDX_W-1:0]] <= 1'b1;
				fill_q     <= fill_q + FILL_W'(1);
				fill_col_q <= wrap_inc(fill_col_q);
				if (fill_col_q == ROWCOL_W'(SIDE - 1)) begin
					fill_row_q <= fill_row_q + ROWCOL_W'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.op)
							OP_KEY: state_q <= ST_IDLE;
							OP_KEY_END: begin
								walk_q  <= '0;
								state_q <= ST_KEY_END;
							end
							OP_PAIR: state_q <= ST_RD_B;
							OP_BAD:  state_q <= ST_BAD;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_KEY_END: begin
					walk_q <= walk_q + LETTER_W'(1);
					if (walk_q == LETTER_W'(LETTERS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_B: state_q <= ST_CALC;
				ST_CALC: state_q <= ST_SQ2;
				ST_SQ2:  state_q <= ST_E2;
				ST_E2:   state_q <= ST_OUT1;
				ST_OUT1: begin
					if (load_ok) begin
						res_q   <= '{cipher_letter: e1_q, bad_letter: 1'b0, last: 1'b0};
						state_q <= ST_OUT2;
					end
				end
				ST_OUT2: begin
					if (load_ok) begin
						res_q   <= '{cipher_letter: e2_q, bad_letter: 1'b0, last: 1'b1};
						state_q <= ST_IDLE;
					end
				end
				ST_BAD: begin
					if (load_ok) begin
						res_q   <= '{cipher_letter: '0, bad_letter: 1'b1, last: 1'b1};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CELLS))
		else $error("square fill count beyond 25");
	a_fill_matches_used: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) == $countones(used_q))
		else $error("fill count disagrees with used letters");
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last && !result_stall) |=>
		(result_valid && result.last && !result.bad_letter))
		else $error("first letter of a pair not followed by the second");
`endif

endmodule

// ----- rtl/core/playfair_cipher_encoder_top.sv -----
// Playfair encoder with configurable omitted and filler letters: top level.
// Depends on pfe_pkg, pfe_front, pfe_queue and pfe_back.
//
// The front end takes one item per cycle whenever its two-entry command queue
// has room; text letters that only open a pair, and text end with nothing
// open, issue no command. The back end runs each queued command through
// two single-port-read RAMs (letter position and square): a key letter is
// placed as it is issued, key end walks all 26 letters after its issue, and
// a pair makes two position reads and two square reads before its first
// result, then gives its second result; a dropped letter gives one result.
// Results leave through an output register, so stalls on the result side
// hold the back end, and reach the front end once the command queue is full.
// The square must be complete before text is sent.
module playfair_cipher_encoder_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  pfe_pkg::item_t                  item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output pfe_pkg::result_t                result,
	input  logic                            cfg_wen,
	input  logic [pfe_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pfe_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import pfe_pkg::*;

	logic [LETTER_W-1:0] omitted_q;
	logic [LETTER_W-1:0] filler_q;
	logic                q_full;
	logic                push;
	cmd_t                push_cmd;
	logic                cmd_valid;
	cmd_t                cmd;
	logic                cmd_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omitted_q <= OMITTED_RESET;
			filler_q  <= FILLER_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_OMITTED: omitted_q <= cfg_wdata;
				CFG_FILLER:  filler_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	pfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.omitted    (omitted_q),
		.filler     (filler_q),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	pfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (cmd_pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd)
	);

	pfe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_pop      (cmd_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for playfair_cipher_encoder_top: builds one square,
// then encrypts directed and random text under several letter settings.
// Depends on pfe_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb;
	import pfe_pkg::*;

	localparam int SETTLE_CYCLES = 100;
	localparam int PHASE_ITEMS   = 150;
	localparam int PHASES        = 6;

	// Letter indexes used by the directed part
	localparam logic [LETTER_W-1:0] LT_A   = 5'd0;
	localparam logic [LETTER_W-1:0] LT_B   = 5'd1;
	localparam logic [LETTER_W-1:0] LT_E   = 5'd4;
	localparam logic [LETTER_W-1:0] LT_F   = 5'd5;
	localparam logic [LETTER_W-1:0] LT_K   = 5'd10;
	localparam logic [LETTER_W-1:0] LT_L   = 5'd11;
	localparam logic [LETTER_W-1:0] LT_O   = 5'd14;
	localparam logic [LETTER_W-1:0] LT_Q   = 5'd16;
	localparam logic [LETTER_W-1:0] LT_X   = 5'd23;
	localparam logic [LETTER_W-1:0] LT_Z   = 5'd25;
	localparam logic [LETTER_W-1:0] LT_TOP = 5'd31;

	localparam result_t NO_RES  = '0;
	localparam result_t BAD_RES = '{cipher_letter: '0, bad_letter: 1'b1, last: 1'b1};

	// One row of the directed part; typed rows carry their own answer
	typedef struct packed {
		item_t       it;
		logic        typed;
		logic [1:0]  n_res;
		result_t     res;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   item_valid;
	logic                   item_stall;
	item_t                  item;
	logic                   result_valid;
	logic                   result_stall;
	result_t                result;
	logic                   cfg_wen;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	// Encoder state as the testbench sees it
	logic [LETTER_W-1:0] sq_cell [CELLS];
	logic [ROWCOL_W-1:0] pos_row [LETTERS];
	logic [ROWCOL_W-1:0] pos_col [LETTERS];
	logic [LETTERS-1:0]  placed_mask;
	int                  fill_n;
	logic [LETTER_W-1:0] held_letter;
	bit                  held_valid;
	logic [LETTER_W-1:0] omit_cfg;
	logic [LETTER_W-1:0] filler_cfg;

	result_t cipher_q [$];
	int      errors = 0;
	int      checked = 0;
	int      burst_left = 0;

	dir_row_t plan [24] = '{
		'{'{ACT_KEY_LETTER, LT_Z},   1'b1, 2'd0, NO_RES},
		'{'{ACT_KEY_LETTER, LT_A},   1'b1, 2'd0, NO_RES},
		'{'{ACT_KEY_LETTER, LT_Z},   1'b1, 2'd0, NO_RES},
		'{'{ACT_KEY_LETTER, LT_Q},   1'b1, 2'd0, NO_RES},
		'{'{ACT_KEY_LETTER, LT_TOP}, 1'b1, 2'd0, NO_RES},
		'{'{ACT_KEY_END,    LT_A},   1'b1, 2'd0, NO_RES},
		'{'{ACT_KEY_LETTER, LT_B},   1'b1, 2'd0, NO_RES},
		'{'{ACT_KEY_END,    LT_TOP}, 1'b1, 2'd0, NO_RES},
		'{'{ACT_TEXT_END,   LT_A},   1'b1, 2'd0, NO_RES},
		'{'{ACT_TEXT_LETTER, LT_Q},   1'b1, 2'd1, BAD_RES},
		'{'{ACT_TEXT_LETTER, LT_TOP}, 1'b1, 2'd1, BAD_RES},
		'{'{ACT_TEXT_LETTER, LT_A},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_LETTER, LT_Z},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_LETTER, LT_L},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_LETTER, LT_L},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_LETTER, LT_O},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_LETTER, LT_X},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_LETTER, LT_X},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_END,    LT_Z},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_LETTER, LT_E},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_LETTER, LT_Q},   1'b1, 2'd1, BAD_RES},
		'{'{ACT_TEXT_LETTER, LT_F},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_LETTER, LT_K},   1'b0, 2'd0, NO_RES},
		'{'{ACT_TEXT_END,    LT_K},   1'b0, 2'd0, NO_RES}
	};

	// Letter settings per random phase; the last phase picks its own
	logic [LETTER_W-1:0] phase_omit [PHASES-1] = '{5'd16, 5'd0, 5'd25, 5'd16, 5'd31};
	logic [LETTER_W-1:0] phase_fill [PHASES-1] = '{5'd23, 5'd25, 5'd0, 5'd31, 5'd23};

	playfair_cipher_encoder_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Square building
	function automatic bit can_place(logic [LETTER_W-1:0] v);
		return v < LETTERS && v != omit_cfg && !placed_mask[v];
	endfunction

	function automatic void square_add(logic [LETTER_W-1:0] v);
		if (fill_n < CELLS && can_place(v)) begin
			sq_cell[fill_n] = v;
			pos_row[v] = ROWCOL_W'(fill_n / SIDE);
			pos_col[v] = ROWCOL_W'(fill_n % SIDE);
			placed_mask[v] = 1'b1;
			fill_n++;
		end
	endfunction

	function automatic logic [LETTER_W-1:0] square_at(int r, int c);
		return sq_cell[(r % SIDE) * SIDE + (c % SIDE)];
	endfunction

	// Same row: right; same column: below; else swap columns
	function automatic void encrypt_pair(logic [LETTER_W-1:0] a, logic [LETTER_W-1:0] b,
			output result_t r0, output result_t r1);
		int ra, ca, rb, cb;
		logic [LETTER_W-1:0] e0, e1;
		ra = 0; ca = 0; rb = 0; cb = 0;
		if (a < LETTERS) begin
			ra = pos_row[a] % SIDE;
			ca = pos_col[a] % SIDE;
		end
		if (b < LETTERS) begin
			rb = pos_row[b] % SIDE;
			cb = pos_col[b] % SIDE;
		end
		if (ra == rb) begin
			e0 = square_at(ra, ca + 1);
			e1 = square_at(rb, cb + 1);
		end else if (ca == cb) begin
			e0 = square_at(ra + 1, ca);
			e1 = square_at(rb + 1, cb);
		end else begin
			e0 = square_at(ra, cb);
			e1 = square_at(rb, ca);
		end
		r0 = '{cipher_letter: e0, bad_letter: 1'b0, last: 1'b0};
		r1 = '{cipher_letter: e1, bad_letter: 1'b0, last: 1'b1};
	endfunction

	// Expected results of one accepted item; updates the tracked state
	function automatic int encode_item(item_t it, output result_t r0, output result_t r1);
		r0 = NO_RES;
		r1 = NO_RES;
		case (action_t'(it.action))
			ACT_KEY_LETTER: begin
				square_add(it.letter);
				return 0;
			end
			ACT_KEY_END: begin
				for (int k = 0; k < LETTERS; k++)
					square_add(5'(k));
				return 0;
			end
			ACT_TEXT_LETTER: begin
				if (it.letter >= LETTERS || it.letter == omit_cfg) begin
					r0 = BAD_RES;
					return 1;
				end
				if (!held_valid) begin
					held_letter = it.letter;
					held_valid = 1'b1;
					return 0;
				end
				// doubled letter: filler goes in, the letter stays open
				if (held_letter == it.letter) begin
					encrypt_pair(held_letter, filler_cfg, r0, r1);
					return 2;
				end
				encrypt_pair(held_letter, it.letter, r0, r1);
				held_valid = 1'b0;
				return 2;
			end
			default: begin
				if (!held_valid)
					return 0;
				encrypt_pair(held_letter, filler_cfg, r0, r1);
				held_valid = 1'b0;
				return 2;
			end
		endcase
	endfunction

	// Text letters that never read an unwritten table entry
	function automatic bit text_ok(logic [LETTER_W-1:0] v);
		return v >= LETTERS || v == omit_cfg || placed_mask[v];
	endfunction

	function automatic void queue_results(int n, result_t r0, result_t r1);
		if (n > 0)
			cipher_q.push_back(r0);
		if (n > 1)
			cipher_q.push_back(r1);
	endfunction

	// One input transfer, with a random gap at the start of each burst
	task automatic send_item(input item_t it, output int n, output result_t r0,
			output result_t r1);
		bit took;
		int gap_len;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap_len > 0) begin
				item_valid <= 1'b0;
				repeat (gap_len) @(posedge clk);
			end
		end
		item_valid <= 1'b1;
		item <= it;
		do begin
			@(negedge clk);
			took = !item_stall;
			@(posedge clk);
		end while (!took);
		burst_left--;
		n = encode_item(it, r0, r1);
	endtask

	// Stop offering, wait for every expected result, then let the back end finish
	task automatic settle_block();
		item_valid <= 1'b0;
		while (cipher_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_settings(input logic [LETTER_W-1:0] om, input logic [LETTER_W-1:0] fl);
		cfg_wen <= 1'b1;
		cfg_index <= CFG_OMITTED;
		cfg_wdata <= om;
		@(posedge clk);
		cfg_index <= CFG_FILLER;
		cfg_wdata <= fl;
		@(posedge clk);
		cfg_wen <= 1'b0;
		omit_cfg = om;
		filler_cfg = fl;
	endtask

	// Stimulus
	initial begin : stimulus
		int n, sel, counted;
		result_t r0, r1;
		item_t nxt;
		logic [LETTER_W-1:0] v, prev_text, om, fl;

		item_valid = 1'b0;
		item = '0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		placed_mask = '0;
		fill_n = 0;
		held_letter = '0;
		held_valid = 1'b0;
		omit_cfg = OMITTED_RESET;
		filler_cfg = FILLER_RESET;
		prev_text = '0;
		for (int i = 0; i < CELLS; i++)
			sq_cell[i] = '0;
		for (int i = 0; i < LETTERS; i++) begin
			pos_row[i] = '0;
			pos_col[i] = '0;
		end

		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Directed part under the reset settings
		foreach (plan[i]) begin
			send_item(plan[i].it, n, r0, r1);
			if (plan[i].typed)
				queue_results(plan[i].n_res, plan[i].res, NO_RES);
			else
				queue_results(n, r0, r1);
		end

		// Random phases, each under its own letter settings
		for (int p = 0; p < PHASES; p++) begin
			settle_block();
			if (p < PHASES - 1) begin
				om = phase_omit[p];
				fl = phase_fill[p];
			end else begin
				om = 5'($urandom_range(0, 31));
				do fl = 5'($urandom_range(0, 31));
				while (!(fl >= LETTERS || placed_mask[fl]));
			end
			write_settings(om, fl);
			counted = 0;
			while (counted < PHASE_ITEMS) begin
				sel = $urandom_range(0, 99);
				nxt.letter = 5'($urandom_range(0, 31));
				if (sel < 3)
					nxt.action = ACT_KEY_LETTER;
				else if (sel < 4)
					nxt.action = ACT_KEY_END;
				else if (sel < 11)
					nxt.action = ACT_TEXT_END;
				else begin
					nxt.action = ACT_TEXT_LETTER;
					if (sel < 16)
						v = $urandom_range(0, 1) ? omit_cfg : 5'($urandom_range(LETTERS, 31));
					else if (sel < 30)
						v = prev_text;
					else if (sel < 36)
						v = filler_cfg;
					else
						v = 5'($urandom_range(0, LETTERS - 1));
					while (!text_ok(v))
						v = 5'($urandom_range(0, LETTERS - 1));
					nxt.letter = v;
					prev_text = v;
				end
				send_item(nxt, n, r0, r1);
				queue_results(n, r0, r1);
				if (sel >= 4)
					counted++;
			end
		end

		settle_block();
		if (errors == 0 && cipher_q.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// Result side: stall patterns, plus one long hold-off once traffic is flowing
	initial begin : result_side
		int mode, seg, hold_left;
		bit hold_done;
		result_stall = 1'b0;
		hold_done = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			seg = $urandom_range(10, 120);
			repeat (seg) begin
				@(posedge clk);
				if (!hold_done && checked >= 30) begin
					hold_done = 1'b1;
					hold_left = 150;
				end
				if (hold_left > 0) begin
					hold_left--;
					result_stall <= 1'b1;
				end else begin
					case (mode)
						0: result_stall <= 1'b0;
						1: result_stall <= ($urandom_range(0, 3) == 0);
						2: result_stall <= ($urandom_range(0, 3) != 0);
						default: result_stall <= ($urandom_range(0, 15) != 0);
					endcase
				end
			end
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(negedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (cipher_q.size() == 0) begin
				$display("%0t: unexpected result %p", $time, result);
				errors++;
			end else begin
				want = cipher_q.pop_front();
				checked++;
				if (result.cipher_letter !== want.cipher_letter) begin
					$display("%0t: cipher_letter expected %0d got %0d", $time,
						want.cipher_letter, result.cipher_letter);
					errors++;
				end
				if (result.bad_letter !== want.bad_letter) begin
					$display("%0t: bad_letter expected %0d got %0d", $time,
						want.bad_letter, result.bad_letter);
					errors++;
				end
				if (result.last !== want.last) begin
					$display("%0t: last expected %0d got %0d", $time, want.last, result.last);
					errors++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#12_000_000;
		$display("tb failed");
		$finish;
	end

endmodule
